// File: design/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the segment/triangle test
// coordinate format, derived datapath widths and pipeline depth
// ----------------------------------------------------------------------------
package sti_pkg;

   localparam int COORD_BITS = 20;
   localparam int VEC_BITS   = 3 * COORD_BITS;
   localparam int TOL_BITS   = 16;
   localparam int FRAC_BITS  = 12;

   // datapath widths
   localparam int DIFF_BITS  = COORD_BITS + 1;           // coordinate difference
   localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;   // difference times normal
   localparam int DIST_BITS  = PROD_BITS + 2;            // plane distance
   localparam int DEN_BITS   = DIST_BITS + 1;            // distance difference
   localparam int NUM_BITS   = DIST_BITS + DIFF_BITS;    // dividend
   localparam int QUO_BITS   = COORD_BITS + 2;           // quotient bits kept
   localparam int QS_BITS    = QUO_BITS + 2;             // signed quotient
   localparam int CROSS_BITS = 2 * DIFF_BITS;            // cross product term
   localparam int MOM_BITS   = CROSS_BITS + 1;           // cross product component
   localparam int EDGE_BITS  = MOM_BITS + COORD_BITS + 3;

   // register stages from request to result
   localparam int LATENCY    = QUO_BITS + 12;

   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(168);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [VEC_BITS-1:0]          vec_type;

   localparam coord_type CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      vec_type st;
      vec_type t0;
      vec_type t1;
      vec_type t2;
      vec_type nv;
   } geo_type;

   typedef struct packed {
      logic                pass;
      logic                zero;
      logic [2:0]          neg;
      logic [2:0]          ovf;
      logic [DEN_BITS-1:0] dm;
      geo_type             geo;
   } ctl_type;

   function automatic coord_type coord(vec_type w, logic [1:0] k);
      coord_type c;
      c = w[k*COORD_BITS +: COORD_BITS];
      return c;
   endfunction

   function automatic vec_type vert(geo_type g, logic [1:0] k);
      vec_type v;
      unique case (k)
         2'd0:    v = g.t0;
         2'd1:    v = g.t1;
         default: v = g.t2;
      endcase
      return v;
   endfunction

endpackage

// File: design/segment_triangle_intersection_top.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersection_top: directed segment vs front-face triangle
// fully pipelined hit test with plane crossing point, one item per cycle
// ----------------------------------------------------------------------------
// usage
//   request: drive req_* and raise start; a beat is taken at each edge with
//   start high and busy low. busy is always low, so a new segment/triangle
//   pair can be issued every cycle.
//   result: rsp_valid strobes for one cycle with rsp_hit and the crossing
//   point; rsp_point_* are zero on a miss. the receiver cannot stall.
//   pipeline: a request beat passes the distance, side test and dividend stages,
//   the pipelined divider that places the crossing point (one range compare
//   stage, then one quotient bit per stage), the rounding, point, edge and
//   result registers; throughput is one result per cycle, in order.
//   csr: one register, the tolerance, written on csr_valid (csr_ready is
//   always high); write it only while no request is in flight.
//   reset: synchronous; clears the pipeline valid bits, so every beat in
//   flight is dropped, and loads the tolerance with 168 (about 1e-5).
// ----------------------------------------------------------------------------
module segment_triangle_intersection_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_seg_start,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_seg_end,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_tri_top,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_tri_left,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_tri_right,
   input  logic [sti_pkg::VEC_BITS-1:0]              req_tri_normal,
   output logic                                      rsp_valid,
   output logic                                      rsp_hit,
   output logic signed [sti_pkg::COORD_BITS-1:0]    rsp_point_x,
   output logic signed [sti_pkg::COORD_BITS-1:0]    rsp_point_y,
   output logic signed [sti_pkg::COORD_BITS-1:0]    rsp_point_z,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [sti_pkg::TOL_BITS-1:0]              csr_data
);
   import sti_pkg::*;

   localparam int ND = QUO_BITS + 1;   // divider stage slots

   logic accept;
   logic [TOL_BITS-1:0] tol_ff;

   // stage 1: offsets from the top vertex and segment direction
   logic v1_ff;
   geo_type g1_ff;
   logic signed [DIFF_BITS-1:0] a1_ff [3];
   logic signed [DIFF_BITS-1:0] b1_ff [3];
   logic signed [DIFF_BITS-1:0] dd1_ff [3];
   // stage 2: per-axis products with the normal
   logic v2_ff;
   geo_type g2_ff;
   logic signed [PROD_BITS-1:0] pa2_ff [3];
   logic signed [PROD_BITS-1:0] pb2_ff [3];
   logic signed [DIFF_BITS-1:0] dd2_ff [3];
   // stage 3: plane distances
   logic v3_ff;
   geo_type g3_ff;
   logic signed [DIST_BITS-1:0] d03_ff, d13_ff;
   logic signed [DIFF_BITS-1:0] dd3_ff [3];
   // stage 4: side test, magnitudes and signs
   logic v4_ff;
   ctl_type c4_in, c4_ff;
   logic [DIST_BITS-1:0] mag0_in, mag0_ff;
   logic [DIFF_BITS-1:0] magd_in [3];
   logic [DIFF_BITS-1:0] magd_ff [3];
   logic signed [DIST_BITS-1:0] tol_d;
   logic signed [DEN_BITS-1:0] den;
   // stage 5: dividends
   logic v5_ff;
   ctl_type c5_ff;
   logic [NUM_BITS-1:0] num5_ff [3];
   // divider stages
   logic vd_ff [ND];
   ctl_type cd_in;
   ctl_type cd_ff [ND];
   logic [DEN_BITS-1:0] rem_ff [ND][3];
   logic [QUO_BITS-1:0] lo_ff [ND][3];
   logic [QUO_BITS-1:0] quo_ff [ND][3];
   logic [DEN_BITS:0] trial_w [QUO_BITS][3];
   logic take_w [QUO_BITS][3];
   logic [2:0] ovf_in;
   // rounding stage
   logic vr_ff;
   ctl_type cr_ff;
   logic signed [QS_BITS-1:0] q_in [3];
   logic signed [QS_BITS-1:0] q_ff [3];
   // saturated crossing point
   logic vp_ff;
   ctl_type cp_ff;
   coord_type p_in [3];
   coord_type p_ff [3];
   // edge stages
   logic ve1_ff, ve2_ff, ve3_ff;
   logic pass_e1_ff, pass_e2_ff, pass_e3_ff;
   vec_type nv_e1_ff, nv_e2_ff, nv_e3_ff;
   coord_type pe1_ff [3];
   coord_type pe2_ff [3];
   coord_type pe3_ff [3];
   logic signed [DIFF_BITS-1:0] s_w [3][3];
   logic signed [DIFF_BITS-1:0] e_w [3][3];
   logic signed [CROSS_BITS-1:0] x_ff [3][6];
   logic signed [MOM_BITS-1:0] m_ff [3][3];
   logic signed [EDGE_BITS-1:0] mn_ff [3][3];
   logic signed [EDGE_BITS-1:0] tol_e;
   logic signed [EDGE_BITS-1:0] esum [3];
   logic hit_in;
   // result register
   logic rsp_valid_ff, rsp_hit_ff;
   coord_type rsp_p_ff [3];

   assign accept    = start & ~busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int k = 0; k < ND; k++) vd_ff[k] <= 1'b0;
         vr_ff <= 1'b0;
         vp_ff <= 1'b0;
         ve1_ff <= 1'b0;
         ve2_ff <= 1'b0;
         ve3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vd_ff[0] <= v5_ff;
         for (int k = 1; k < ND; k++) vd_ff[k] <= vd_ff[k-1];
         vr_ff <= vd_ff[ND-1];
         vp_ff <= vr_ff;
         ve1_ff <= vp_ff;
         ve2_ff <= ve1_ff;
         ve3_ff <= ve2_ff;
         rsp_valid_ff <= ve3_ff;
      end
   end

   // stages 1 to 3: plane distances d0, d1
   always_ff @(posedge clock) begin
      g1_ff <= '{st: req_seg_start, t0: req_tri_top, t1: req_tri_left,
                 t2: req_tri_right, nv: req_tri_normal};
      for (int i = 0; i < 3; i++) begin
         a1_ff[i]  <= DIFF_BITS'(coord(req_seg_start, 2'(i)))
                    - DIFF_BITS'(coord(req_tri_top, 2'(i)));
         b1_ff[i]  <= DIFF_BITS'(coord(req_seg_end, 2'(i)))
                    - DIFF_BITS'(coord(req_tri_top, 2'(i)));
         dd1_ff[i] <= DIFF_BITS'(coord(req_seg_end, 2'(i)))
                    - DIFF_BITS'(coord(req_seg_start, 2'(i)));
      end
      g2_ff <= g1_ff;
      for (int i = 0; i < 3; i++) begin
         pa2_ff[i] <= PROD_BITS'(a1_ff[i]) * PROD_BITS'(coord(g1_ff.nv, 2'(i)));
         pb2_ff[i] <= PROD_BITS'(b1_ff[i]) * PROD_BITS'(coord(g1_ff.nv, 2'(i)));
         dd2_ff[i] <= dd1_ff[i];
      end
      g3_ff  <= g2_ff;
      d03_ff <= DIST_BITS'(pa2_ff[0]) + DIST_BITS'(pa2_ff[1]) + DIST_BITS'(pa2_ff[2]);
      d13_ff <= DIST_BITS'(pb2_ff[0]) + DIST_BITS'(pb2_ff[1]) + DIST_BITS'(pb2_ff[2]);
      for (int i = 0; i < 3; i++) dd3_ff[i] <= dd2_ff[i];
   end

   // stage 4: front-to-back test, sign and magnitude split for the divider
   always_comb begin
      tol_d = $signed(DIST_BITS'(tol_ff));
      den   = DEN_BITS'(d03_ff) - DEN_BITS'(d13_ff);
      mag0_in = d03_ff[DIST_BITS-1] ? DIST_BITS'(-d03_ff) : DIST_BITS'(d03_ff);
      c4_in.pass = (d03_ff > -tol_d) && (d13_ff < tol_d);
      c4_in.zero = (den == '0);
      c4_in.ovf  = '0;
      c4_in.dm   = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
      c4_in.geo  = g3_ff;
      for (int i = 0; i < 3; i++) begin
         magd_in[i] = dd3_ff[i][DIFF_BITS-1] ? DIFF_BITS'(-dd3_ff[i])
                                             : DIFF_BITS'(dd3_ff[i]);
         c4_in.neg[i] = d03_ff[DIST_BITS-1] ^ dd3_ff[i][DIFF_BITS-1] ^ den[DEN_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      c4_ff   <= c4_in;
      mag0_ff <= mag0_in;
      for (int i = 0; i < 3; i++) magd_ff[i] <= magd_in[i];
      // stage 5: dividend |d0| * |direction|
      c5_ff <= c4_ff;
      for (int i = 0; i < 3; i++) begin
         num5_ff[i] <= NUM_BITS'(mag0_ff) * NUM_BITS'(magd_ff[i]);
      end
   end

   // divider: quotients of 2^QUO_BITS or more only saturate the point, so
   // the top part is compared once and the low bits come one per stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ovf_in[i] = DEN_BITS'(num5_ff[i][NUM_BITS-1:QUO_BITS]) >= c5_ff.dm;
      end
      cd_in     = c5_ff;
      cd_in.ovf = ovf_in;
      for (int k = 0; k < QUO_BITS; k++) begin
         for (int i = 0; i < 3; i++) begin
            trial_w[k][i] = {rem_ff[k][i], lo_ff[k][i][QUO_BITS-1]};
            take_w[k][i]  = trial_w[k][i] >= {1'b0, cd_ff[k].dm};
         end
      end
   end

   always_ff @(posedge clock) begin
      cd_ff[0] <= cd_in;
      for (int i = 0; i < 3; i++) begin
         rem_ff[0][i] <= DEN_BITS'(num5_ff[i][NUM_BITS-1:QUO_BITS]);
         lo_ff[0][i]  <= num5_ff[i][QUO_BITS-1:0];
         quo_ff[0][i] <= '0;
      end
      for (int k = 1; k < ND; k++) begin
         cd_ff[k] <= cd_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            rem_ff[k][i] <= take_w[k-1][i]
                          ? DEN_BITS'(trial_w[k-1][i] - {1'b0, cd_ff[k-1].dm})
                          : DEN_BITS'(trial_w[k-1][i]);
            lo_ff[k][i]  <= {lo_ff[k-1][i][QUO_BITS-2:0], 1'b0};
            quo_ff[k][i] <= {quo_ff[k-1][i][QUO_BITS-2:0], take_w[k-1][i]};
         end
      end
   end

   // round to nearest, ties away from zero, then apply the sign
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QUO_BITS:0] qm;
         qm = {1'b0, quo_ff[ND-1][i]}
            + (QUO_BITS+1)'({rem_ff[ND-1][i], 1'b0} >= {1'b0, cd_ff[ND-1].dm});
         if (cd_ff[ND-1].ovf[i]) qm = (QUO_BITS+1)'(1) << QUO_BITS;
         if (cd_ff[ND-1].zero)   qm = '0;
         q_in[i] = cd_ff[ND-1].neg[i] ? -$signed(QS_BITS'(qm)) : $signed(QS_BITS'(qm));
      end
   end

   // crossing point with saturation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [QS_BITS:0] sum;
         sum = (QS_BITS+1)'(coord(cr_ff.geo.st, 2'(i))) + (QS_BITS+1)'(q_ff[i]);
         if (sum > (QS_BITS+1)'(CMAX))      p_in[i] = CMAX;
         else if (sum < (QS_BITS+1)'(CMIN)) p_in[i] = CMIN;
         else                               p_in[i] = COORD_BITS'(sum);
      end
   end

   // edge vectors: from vertex minus point, and edge direction
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            s_w[j][i] = DIFF_BITS'(coord(vert(cp_ff.geo, 2'(j)), 2'(i)))
                      - DIFF_BITS'(p_ff[i]);
            e_w[j][i] = DIFF_BITS'(coord(vert(cp_ff.geo, (j == 2) ? 2'd0 : 2'(j + 1)), 2'(i)))
                      - DIFF_BITS'(coord(vert(cp_ff.geo, 2'(j)), 2'(i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      cr_ff <= cd_ff[ND-1];
      for (int i = 0; i < 3; i++) q_ff[i] <= q_in[i];
      cp_ff <= cr_ff;
      for (int i = 0; i < 3; i++) p_ff[i] <= p_in[i];
      // edge stage 1: cross product terms
      pass_e1_ff <= cp_ff.pass;
      nv_e1_ff   <= cp_ff.geo.nv;
      for (int i = 0; i < 3; i++) pe1_ff[i] <= p_ff[i];
      for (int j = 0; j < 3; j++) begin
         x_ff[j][0] <= CROSS_BITS'(s_w[j][1]) * CROSS_BITS'(e_w[j][2]);
         x_ff[j][1] <= CROSS_BITS'(s_w[j][2]) * CROSS_BITS'(e_w[j][1]);
         x_ff[j][2] <= CROSS_BITS'(s_w[j][2]) * CROSS_BITS'(e_w[j][0]);
         x_ff[j][3] <= CROSS_BITS'(s_w[j][0]) * CROSS_BITS'(e_w[j][2]);
         x_ff[j][4] <= CROSS_BITS'(s_w[j][0]) * CROSS_BITS'(e_w[j][1]);
         x_ff[j][5] <= CROSS_BITS'(s_w[j][1]) * CROSS_BITS'(e_w[j][0]);
      end
      // edge stage 2: cross product components
      pass_e2_ff <= pass_e1_ff;
      nv_e2_ff   <= nv_e1_ff;
      for (int i = 0; i < 3; i++) pe2_ff[i] <= pe1_ff[i];
      for (int j = 0; j < 3; j++) begin
         m_ff[j][0] <= MOM_BITS'(x_ff[j][0]) - MOM_BITS'(x_ff[j][1]);
         m_ff[j][1] <= MOM_BITS'(x_ff[j][2]) - MOM_BITS'(x_ff[j][3]);
         m_ff[j][2] <= MOM_BITS'(x_ff[j][4]) - MOM_BITS'(x_ff[j][5]);
      end
      // edge stage 3: products with the normal
      pass_e3_ff <= pass_e2_ff;
      nv_e3_ff   <= nv_e2_ff;
      for (int i = 0; i < 3; i++) pe3_ff[i] <= pe2_ff[i];
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            mn_ff[j][i] <= EDGE_BITS'(m_ff[j][i]) * EDGE_BITS'(coord(nv_e2_ff, 2'(i)));
         end
      end
   end

   // final edge sums: inside when dot + tolerance * 4096 is positive
   always_comb begin
      tol_e  = $signed(EDGE_BITS'({tol_ff, FRAC_BITS'(0)}));
      hit_in = pass_e3_ff;
      for (int j = 0; j < 3; j++) begin
         esum[j] = mn_ff[j][0] + mn_ff[j][1] + mn_ff[j][2] + tol_e;
         if (!(esum[j] > 0)) hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= hit_in;
      for (int i = 0; i < 3; i++) rsp_p_ff[i] <= hit_in ? pe3_ff[i] : '0;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_point_x = rsp_p_ff[0];
   assign rsp_point_y = rsp_p_ff[1];
   assign rsp_point_z = rsp_p_ff[2];

endmodule

// File: design/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker: port-level checks of the segment/triangle test
// fixed latency, no spurious beats, zeroed point on a miss
// ----------------------------------------------------------------------------
module sti_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic                                   rsp_hit,
   input logic signed [sti_pkg::COORD_BITS-1:0] rsp_point_x,
   input logic signed [sti_pkg::COORD_BITS-1:0] rsp_point_y,
   input logic signed [sti_pkg::COORD_BITS-1:0] rsp_point_z
);
   import sti_pkg::*;

   // every request beat yields a result beat after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result beat missing");

   // no result beat without a matching request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without request");

   // a miss reports the origin
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_point_x == 0 && rsp_point_y == 0 && rsp_point_z == 0)
      else $error("nonzero point on miss");

endmodule

bind segment_triangle_intersection_top sti_checker u_sti_checker (.*);
